// ===== rtl/core/lin_ups_pkg.sv =====
// Shared types and constants for the linear interpolating upsampler.
// No dependencies; used by every module under rtl/core.
`default_nettype none
package lin_ups_pkg;

  localparam int PT_W      = 32;  // Q16.16 point width
  localparam int IN_W      = 13;  // input_count register width
  localparam int OUT_W     = 18;  // output_count register width
  localparam int CFG_W     = 18;  // widest register
  localparam int CFG_IDX_W = 1;
  localparam int K_W       = 6;   // inserts per segment
  localparam int DIV_W     = 33;  // dividend / quotient width
  localparam int DVS_W     = 13;  // divisor / remainder width
  localparam int STEP_W    = 33;

  localparam int MAX_INSERT  = 62;
  localparam int MAX_POINTS  = 4096;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [IN_W-1:0]  IN_CNT_RESET  = IN_W'(2);
  localparam logic [OUT_W-1:0] OUT_CNT_RESET = OUT_W'(3);

  localparam logic [CFG_IDX_W-1:0] CFG_INPUT_COUNT  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_COUNT = 1'b1;

  // One segment's work, handed from the front to the back.
  typedef struct packed {
    logic                     err;
    logic                     tail;   // also emit the end point
    logic [K_W-1:0]           k;
    logic [PT_W-1:0]          a;
    logic signed [STEP_W-1:0] step;
    logic [PT_W-1:0]          point;
  } cmd_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quot;
    logic [DVS_W-1:0] rem;
  } div_rsp_t;

endpackage
`default_nettype wire

// ===== rtl/core/lin_ups_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
// Depends on lin_ups_pkg.
`default_nettype none
module lin_ups_div (
  input  wire                    clk,
  input  wire                    rst,
  input  lin_ups_pkg::div_req_t  req,
  output lin_ups_pkg::div_rsp_t  rsp
);

  localparam int CNT_W = $clog2(lin_ups_pkg::DIV_W);

  logic                           run;
  logic                           done;
  logic [CNT_W-1:0]               cnt;
  logic [lin_ups_pkg::DIV_W-1:0]  dvd;
  logic [lin_ups_pkg::DIV_W-1:0]  quot;
  logic [lin_ups_pkg::DVS_W-1:0]  rem;
  logic [lin_ups_pkg::DVS_W-1:0]  dvs;

  logic [lin_ups_pkg::DVS_W:0]    part;
  logic [lin_ups_pkg::DVS_W:0]    trial;
  logic                           ge;

  assign part  = {rem, dvd[lin_ups_pkg::DIV_W-1]};
  assign trial = part - {1'b0, dvs};
  assign ge    = (part >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        run  <= 1'b1;
        cnt  <= '0;
        dvd  <= req.dividend;
        dvs  <= req.divisor;
        rem  <= '0;
        quot <= '0;
      end else if (run) begin
        rem  <= ge ? trial[lin_ups_pkg::DVS_W-1:0] : part[lin_ups_pkg::DVS_W-1:0];
        quot <= {quot[lin_ups_pkg::DIV_W-2:0], ge};
        dvd  <= {dvd[lin_ups_pkg::DIV_W-2:0], 1'b0};
        cnt  <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(lin_ups_pkg::DIV_W - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quot = quot;
  assign rsp.rem  = rem;

endmodule
`default_nettype wire

// ===== rtl/core/lin_ups_front.sv =====
// Front end: configuration registers, input acceptance, segment split and
// step computation on the shared divider. Depends on lin_ups_pkg.
`default_nettype none
module lin_ups_front (
  input  wire                                    clk,
  input  wire                                    rst,
  input  wire                                    cfg_we,
  input  wire [lin_ups_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire [lin_ups_pkg::CFG_W-1:0]           cfg_data,
  input  wire                                    s_tvalid,
  output logic                                   s_tready,
  input  wire [lin_ups_pkg::PT_W-1:0]            s_tdata,
  output lin_ups_pkg::div_req_t                  div_req,
  input  lin_ups_pkg::div_rsp_t                  div_rsp,
  input  wire                                    q_full,
  output logic                                   q_push,
  output lin_ups_pkg::cmd_t                      q_cmd
);

  typedef enum logic [1:0] {S_CALC, S_IDLE, S_SEG} state_t;

  state_t                              state;
  logic [lin_ups_pkg::IN_W-1:0]        in_cnt;
  logic [lin_ups_pkg::OUT_W-1:0]       out_cnt;
  logic                                cfg_bad;
  logic [lin_ups_pkg::K_W-1:0]         base;
  logic [lin_ups_pkg::DVS_W-1:0]       extra;
  logic [lin_ups_pkg::PT_W-1:0]        prev;
  logic [lin_ups_pkg::IN_W-1:0]        seg_idx;
  logic                                div_go;
  logic [lin_ups_pkg::DIV_W-1:0]       mag;
  logic [lin_ups_pkg::DVS_W-1:0]       item_dvs;
  logic [lin_ups_pkg::PT_W-1:0]        pend_a;
  logic [lin_ups_pkg::PT_W-1:0]        pend_p;
  logic [lin_ups_pkg::K_W-1:0]         pend_k;
  logic                                pend_tail;
  logic                                pend_neg;

  logic                                s_acc;
  logic                                range_bad;
  logic [lin_ups_pkg::OUT_W-1:0]       added;
  logic [lin_ups_pkg::DVS_W-1:0]       segs;
  logic [lin_ups_pkg::IN_W-1:0]        seg;
  logic [lin_ups_pkg::K_W-1:0]         k;
  logic                                tail;
  logic signed [lin_ups_pkg::DIV_W-1:0] diff;
  logic [lin_ups_pkg::DIV_W-1:0]       quot_neg;

  assign s_tready = (state == S_IDLE) && !q_full;
  assign s_acc    = s_tvalid && s_tready;

  assign range_bad = (in_cnt < lin_ups_pkg::IN_W'(2)) ||
                     ({4'b0, in_cnt} > (lin_ups_pkg::IN_W + 4)'(lin_ups_pkg::MAX_POINTS)) ||
                     (out_cnt <= {5'b0, in_cnt});
  assign added = out_cnt - {5'b0, in_cnt};
  assign segs  = lin_ups_pkg::DVS_W'(in_cnt - lin_ups_pkg::IN_W'(1));

  assign seg  = seg_idx - lin_ups_pkg::IN_W'(1);
  assign k    = base + lin_ups_pkg::K_W'({lin_ups_pkg::DVS_W'(seg) < extra});
  assign tail = ({1'b0, seg_idx} + (lin_ups_pkg::IN_W + 1)'(1)) >= {1'b0, in_cnt};
  assign diff = {s_tdata[lin_ups_pkg::PT_W-1], s_tdata} - {prev[lin_ups_pkg::PT_W-1], prev};

  assign quot_neg = -div_rsp.quot;

  always_comb begin
    div_req.start = div_go;
    if (state == S_CALC) begin
      div_req.dividend = lin_ups_pkg::DIV_W'(added);
      div_req.divisor  = segs;
    end else begin
      div_req.dividend = mag;
      div_req.divisor  = item_dvs;
    end
  end

  always_comb begin
    q_push = (s_acc && cfg_bad) || ((state == S_SEG) && div_rsp.done);
    q_cmd.err   = (state != S_SEG);
    q_cmd.tail  = pend_tail;
    q_cmd.k     = pend_k;
    q_cmd.a     = pend_a;
    q_cmd.step  = pend_neg ? quot_neg : div_rsp.quot;
    q_cmd.point = pend_p;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CALC;
      div_go  <= 1'b1;
      in_cnt  <= lin_ups_pkg::IN_CNT_RESET;
      out_cnt <= lin_ups_pkg::OUT_CNT_RESET;
      cfg_bad <= 1'b0;
      seg_idx <= '0;
      base    <= '0;
      extra   <= '0;
      prev    <= '0;
    end else begin
      div_go <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          lin_ups_pkg::CFG_INPUT_COUNT:  in_cnt  <= cfg_data[lin_ups_pkg::IN_W-1:0];
          lin_ups_pkg::CFG_OUTPUT_COUNT: out_cnt <= cfg_data[lin_ups_pkg::OUT_W-1:0];
          default: ;
        endcase
        // restart the vector and re-split the segments
        seg_idx <= '0;
        state   <= S_CALC;
        div_go  <= 1'b1;
      end else begin
        case (state)
          S_CALC: begin
            // drop a done left over from a split that a write cut short
            if (div_rsp.done && !div_go) begin
              base    <= div_rsp.quot[lin_ups_pkg::K_W-1:0];
              extra   <= div_rsp.rem;
              cfg_bad <= range_bad ||
                         (div_rsp.quot > lin_ups_pkg::DIV_W'(lin_ups_pkg::MAX_INSERT)) ||
                         ((div_rsp.quot == lin_ups_pkg::DIV_W'(lin_ups_pkg::MAX_INSERT)) &&
                          (div_rsp.rem != '0));
              state   <= S_IDLE;
            end
          end
          S_IDLE: begin
            if (s_acc) begin
              if (cfg_bad) begin
                seg_idx <= '0;
              end else if (seg_idx == '0) begin
                prev    <= s_tdata;
                seg_idx <= lin_ups_pkg::IN_W'(1);
              end else begin
                pend_a    <= prev;
                pend_p    <= s_tdata;
                pend_k    <= k;
                pend_tail <= tail;
                pend_neg  <= diff[lin_ups_pkg::DIV_W-1];
                mag       <= diff[lin_ups_pkg::DIV_W-1] ? -diff : diff;
                item_dvs  <= lin_ups_pkg::DVS_W'(k) + lin_ups_pkg::DVS_W'(1);
                div_go    <= 1'b1;
                prev      <= s_tdata;
                seg_idx   <= tail ? '0 : seg_idx + lin_ups_pkg::IN_W'(1);
                state     <= S_SEG;
              end
            end
          end
          S_SEG: begin
            if (div_rsp.done) begin
              state <= S_IDLE;
            end
          end
          default: state <= S_IDLE;
        endcase
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/lin_ups_queue.sv =====
// Short command queue between the front and the back end.
// Depends on lin_ups_pkg.
`default_nettype none
module lin_ups_queue #(
  parameter int DEPTH = lin_ups_pkg::QUEUE_DEPTH
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                push,
  input  lin_ups_pkg::cmd_t  push_cmd,
  input  wire                pop,
  output lin_ups_pkg::cmd_t  head,
  output logic               full,
  output logic               empty
);

  localparam int PW = $clog2(DEPTH);

  lin_ups_pkg::cmd_t mem [DEPTH];
  logic [PW-1:0]     wr_ptr;
  logic [PW-1:0]     rd_ptr;
  logic [PW:0]       count;

  assign full  = (count == (PW + 1)'(DEPTH));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + (PW + 1)'(1);
        2'b01:   count <= count - (PW + 1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/lin_ups_back.sv =====
// Back end: walks one segment command and emits its words through the
// output register. Depends on lin_ups_pkg.
`default_nettype none
module lin_ups_back (
  input  wire                              clk,
  input  wire                              rst,
  input  lin_ups_pkg::cmd_t                head,
  input  wire                              empty,
  output logic                             pop,
  output logic                             m_tvalid,
  input  wire                              m_tready,
  output logic [lin_ups_pkg::PT_W-1:0]     m_tdata,
  output logic                             m_tlast,
  output logic                             m_tuser
);

  lin_ups_pkg::cmd_t                      cur;
  logic                                   busy;
  logic                                   tail_ph;
  logic [lin_ups_pkg::K_W-1:0]            j;
  logic signed [lin_ups_pkg::STEP_W-1:0]  acc;
  logic                                   adv;

  assign adv = !m_tvalid || m_tready;
  assign pop = !busy && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (pop) begin
        cur     <= head;
        busy    <= 1'b1;
        tail_ph <= 1'b0;
        j       <= '0;
        acc     <= lin_ups_pkg::STEP_W'(signed'(head.a));
      end
      if (adv) begin
        m_tvalid <= busy;
        if (busy) begin
          if (cur.err) begin
            m_tdata <= '0;
            m_tlast <= 1'b1;
            m_tuser <= 1'b1;
            busy    <= 1'b0;
          end else if (tail_ph) begin
            m_tdata <= cur.point;
            m_tlast <= 1'b1;
            m_tuser <= 1'b0;
            busy    <= 1'b0;
          end else begin
            m_tdata <= acc[lin_ups_pkg::PT_W-1:0];
            m_tlast <= (j == cur.k) && !cur.tail;
            m_tuser <= 1'b0;
            if (j == cur.k) begin
              // finish the segment, or go on to the end point
              if (cur.tail) begin
                tail_ph <= 1'b1;
              end else begin
                busy <= 1'b0;
              end
            end else begin
              j   <= j + lin_ups_pkg::K_W'(1);
              acc <= acc + cur.step;
            end
          end
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/linear_interpolating_upsampler.sv =====
// Linear interpolating upsampler, top level.
// Instantiates lin_ups_front, lin_ups_div, lin_ups_queue and lin_ups_back.
//
// s_tvalid/s_tready/s_tdata carry one signed Q16.16 point per word;
// m_tvalid/m_tready/m_tdata carry the emitted points, m_tlast marks the last
// word caused by one point, m_tuser flags a bad configuration (then m_tdata
// is zero and every point gives exactly one word). cfg_we/cfg_index/cfg_data
// write input_count (0) or output_count (1); each write restarts the vector.
// After reset and after every register write the front re-splits the
// segments on the shared divider, and s_tready stays low until the split
// is done. The first point of a vector is taken and emits nothing. Each
// later point holds the front for a serial divide of the segment
// difference on the shared divider, then queues one command. The back
// fetches each command and emits its words, k+1 interpolated samples and
// on the final point also the end point, while the front works on the
// next point.
// A low m_tready holds the output register; the queue then fills and
// s_tready drops. Reset clears all control state and the queue.
`default_nettype none
module linear_interpolating_upsampler #(
  parameter int QUEUE_DEPTH = lin_ups_pkg::QUEUE_DEPTH
) (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                cfg_we,
  input  wire [lin_ups_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire [lin_ups_pkg::CFG_W-1:0]       cfg_data,
  input  wire                                s_tvalid,
  output logic                               s_tready,
  input  wire [lin_ups_pkg::PT_W-1:0]        s_tdata,   // [31:0] point
  output logic                               m_tvalid,
  input  wire                                m_tready,
  output logic [lin_ups_pkg::PT_W-1:0]       m_tdata,   // [31:0] sample
  output logic                               m_tlast,
  output logic                               m_tuser    // [0] error
);

  lin_ups_pkg::div_req_t div_req;
  lin_ups_pkg::div_rsp_t div_rsp;
  lin_ups_pkg::cmd_t     q_cmd;
  lin_ups_pkg::cmd_t     q_head;
  logic                  q_push;
  logic                  q_pop;
  logic                  q_full;
  logic                  q_empty;

  lin_ups_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .div_req   (div_req),
    .div_rsp   (div_rsp),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (q_cmd)
  );

  lin_ups_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  lin_ups_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_cmd),
    .pop      (q_pop),
    .head     (q_head),
    .full     (q_full),
    .empty    (q_empty)
  );

  lin_ups_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (q_head),
    .empty    (q_empty),
    .pop      (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule
`default_nettype wire

// ===== rtl/core/lin_ups_checker.sv =====
// Port-level checks for the linear interpolating upsampler, bound to the
// top level. Depends on lin_ups_pkg.
`default_nettype none
module lin_ups_checker (
  input wire                                clk,
  input wire                                rst,
  input wire                                cfg_we,
  input wire                                s_tready,
  input wire                                m_tvalid,
  input wire                                m_tready,
  input wire [lin_ups_pkg::PT_W-1:0]        m_tdata,
  input wire                                m_tlast,
  input wire                                m_tuser
);

  // output register comes up empty
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  // a register write re-splits the segments before new input is taken
  a_cfg_blocks: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> !s_tready)
    else $error("input accepted right after a register write");

  // an error word is a zero sample that closes its point
  a_err_word: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tlast && (m_tdata == '0)))
    else $error("error word is not a zero last word");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=>
      (m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser)))
    else $error("stalled output word changed");

endmodule

bind linear_interpolating_upsampler lin_ups_checker u_lin_ups_checker (
  .clk      (clk),
  .rst      (rst),
  .cfg_we   (cfg_we),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .m_tuser  (m_tuser)
);
`default_nettype wire

// ===== sim/linear_interpolating_upsampler_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for linear_interpolating_upsampler.
// Streams vectors of Q16.16 points under many count settings and checks each
// output word against an interpolation model kept in the bench; uses lin_ups_pkg.
module linear_interpolating_upsampler_tb;

  typedef struct packed {
    logic [lin_ups_pkg::PT_W-1:0] sample;
    logic                         last;
    logic                         err;
  } word_t;

  logic                              clk = 1'b0;
  logic                              rst = 1'b1;
  logic                              cfg_we = 1'b0;
  logic [lin_ups_pkg::CFG_IDX_W-1:0] cfg_index = lin_ups_pkg::CFG_INPUT_COUNT;
  logic [lin_ups_pkg::CFG_W-1:0]     cfg_data = '0;
  logic                              s_tvalid = 1'b0;
  logic                              s_tready;
  logic [lin_ups_pkg::PT_W-1:0]      s_tdata = '0;   // [31:0] point
  logic                              m_tvalid;
  logic                              m_tready = 1'b0;
  logic [lin_ups_pkg::PT_W-1:0]      m_tdata;        // [31:0] sample
  logic                              m_tlast;
  logic                              m_tuser;        // [0] error

  // Interpolation model: register copies and vector progress.
  logic [lin_ups_pkg::IN_W-1:0]         in_cnt;
  logic [lin_ups_pkg::OUT_W-1:0]        out_cnt;
  logic signed [lin_ups_pkg::PT_W-1:0]  prev_pt;
  logic [11:0]                          seg_idx;
  logic [lin_ups_pkg::K_W-1:0]          base_ins;
  logic [11:0]                          extra_segs;

  word_t                        expected_words[$];
  logic [lin_ups_pkg::PT_W-1:0] pending_points[$];
  int              points_queued = 0;
  int              points_taken = 0;
  int              fails = 0;
  bit              idle_on = 1'b1;
  int              hold_reqs = 0;
  int              holds_taken = 0;
  int              send_gap = 0;
  int              recv_gap = 0;
  int              hold_cnt = 0;

  linear_interpolating_upsampler dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit split_invalid();
    int unsigned segs, added, base;
    if (in_cnt < 2 || in_cnt > lin_ups_pkg::MAX_POINTS || out_cnt <= in_cnt) return 1'b1;
    segs  = in_cnt - 1;
    added = out_cnt - in_cnt;
    base  = added / segs;
    return base > lin_ups_pkg::MAX_INSERT ||
           (base == lin_ups_pkg::MAX_INSERT && added % segs != 0);
  endfunction

  function automatic void interpolate_point(logic [lin_ups_pkg::PT_W-1:0] pt);
    int unsigned segs, added;
    longint      a, stp, k, n;
    bit          tail;
    word_t       w;
    if (split_invalid()) begin
      seg_idx = '0;
      w.sample = '0;
      w.last   = 1'b1;
      w.err    = 1'b1;
      expected_words.push_back(w);
      return;
    end
    // First point of a vector: latch the split, emit nothing
    if (seg_idx == 0) begin
      segs       = in_cnt - 1;
      added      = out_cnt - in_cnt;
      base_ins   = lin_ups_pkg::K_W'(added / segs);
      extra_segs = 12'(added % segs);
      prev_pt    = pt;
      seg_idx    = 12'd1;
      return;
    end
    k    = base_ins + (((seg_idx - 12'd1) < extra_segs) ? 1 : 0);
    tail = (seg_idx + 1 >= in_cnt);
    a    = prev_pt;
    stp  = (longint'($signed(pt)) - a) / (k + 1);
    n    = k + 1 + tail;
    for (longint i = 0; i < n; i++) begin
      w.sample = (i <= k) ? lin_ups_pkg::PT_W'(a + i * stp) : pt;
      w.last   = (i == n - 1);
      w.err    = 1'b0;
      expected_words.push_back(w);
    end
    seg_idx = tail ? 12'd0 : seg_idx + 12'd1;
    prev_pt = pt;
  endfunction

  function automatic logic [lin_ups_pkg::PT_W-1:0] pick_point();
    logic [lin_ups_pkg::PT_W-1:0] v;
    case ($urandom_range(0, 9))
      0:       v = 32'h7FFF_FFFF;
      1:       v = 32'h8000_0000;
      2, 3, 4: v = $urandom();
      default: v = $urandom_range(0, 32'h001F_FFFF) - 32'h0010_0000;
    endcase
    return v;
  endfunction

  // Track register writes and accepted points in the model
  always @(posedge clk) begin
    if (rst) begin
      in_cnt     = lin_ups_pkg::IN_CNT_RESET;
      out_cnt    = lin_ups_pkg::OUT_CNT_RESET;
      prev_pt    = '0;
      seg_idx    = '0;
      base_ins   = '0;
      extra_segs = '0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == lin_ups_pkg::CFG_INPUT_COUNT) in_cnt = cfg_data[lin_ups_pkg::IN_W-1:0];
        else out_cnt = cfg_data[lin_ups_pkg::OUT_W-1:0];
        seg_idx = '0;
      end
      if (s_tvalid && s_tready) begin
        interpolate_point(s_tdata);
        points_taken++;
      end
    end
  end

  // Point driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        s_tvalid <= 1'b0;
      end else if (pending_points.size() > 0) begin
        s_tdata  <= pending_points.pop_front();
        s_tvalid <= 1'b1;
        if (idle_on && $urandom_range(0, 3) == 0) send_gap <= $urandom_range(1, 7);
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Sample monitor and receiver stalls
  always @(posedge clk) begin
    word_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_words.size() == 0) begin
          fails++;
          $display("%0t: unexpected word: expected none, actual sample=%h last=%b error=%b",
                   $time, m_tdata, m_tlast, m_tuser);
        end else begin
          want = expected_words.pop_front();
          if (m_tdata !== want.sample || m_tlast !== want.last ||
              m_tuser !== want.err) begin
            fails++;
            $display({"%0t: mismatch: expected sample=%h last=%b error=%b, ",
                      "actual sample=%h last=%b error=%b"},
                     $time, want.sample, want.last, want.err, m_tdata, m_tlast, m_tuser);
          end
        end
      end
      if (hold_reqs != holds_taken) begin
        holds_taken <= holds_taken + 1;
        hold_cnt    <= 600;
        m_tready    <= 1'b0;
      end else if (hold_cnt > 0) begin
        hold_cnt <= hold_cnt - 1;
        m_tready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        if (idle_on && $urandom_range(0, 4) == 0) recv_gap <= $urandom_range(1, 7);
      end
    end
  end

  task automatic write_reg(logic [lin_ups_pkg::CFG_IDX_W-1:0] idx, int unsigned val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= lin_ups_pkg::CFG_W'(val);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_counts(int unsigned ic, int unsigned oc);
    write_reg(lin_ups_pkg::CFG_INPUT_COUNT, ic);
    write_reg(lin_ups_pkg::CFG_OUTPUT_COUNT, oc);
  endtask

  task automatic push_point(logic [lin_ups_pkg::PT_W-1:0] v);
    pending_points.push_back(v);
    points_queued++;
  endtask

  // Wait until every word is taken and every sample seen, then let the
  // front finish any first point that caused no output
  task automatic settle();
    do @(negedge clk);
    while (points_taken != points_queued || expected_words.size() != 0);
    repeat (100) @(negedge clk);
  endtask

  initial begin
    int unsigned ic, oc, segs, nv, r, last_ic;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    settle();

    // Reset setting: one insert per segment, full-scale swings
    push_point(32'h7FFF_FFFF);
    push_point(32'h8000_0000);
    push_point(32'h8000_0000);
    push_point(32'h7FFF_FFFF);
    push_point(32'h0);
    push_point(32'h0);
    settle();

    // Bad settings: one flagged word per point
    set_counts(2, 2);
    push_point(32'h0000_0005);
    push_point(32'hFFFF_FFFB);
    settle();
    set_counts(1, 10);
    push_point(pick_point());
    settle();
    set_counts(0, 0);
    push_point(pick_point());
    settle();
    set_counts(8191, 262143);
    push_point(pick_point());
    settle();
    // too many inserts: full base with a remainder, then base over the cap
    set_counts(3, 3 + 2 * lin_ups_pkg::MAX_INSERT + 1);
    push_point(pick_point());
    push_point(pick_point());
    settle();
    set_counts(2, 2 + lin_ups_pkg::MAX_INSERT + 1);
    push_point(pick_point());
    settle();

    // Largest insert counts
    set_counts(2, 2 + lin_ups_pkg::MAX_INSERT);
    push_point(32'h7FFF_FFFF);
    push_point(32'h8000_0000);
    settle();
    set_counts(3, 3 + 2 * lin_ups_pkg::MAX_INSERT);
    push_point(32'h8000_0000);
    push_point(32'h7FFF_FFFF);
    push_point(32'h8000_0000);
    settle();

    // Largest vector, partly sent, with a long receiver hold-off
    set_counts(lin_ups_pkg::MAX_POINTS,
               lin_ups_pkg::MAX_POINTS +
               (lin_ups_pkg::MAX_POINTS - 1) * lin_ups_pkg::MAX_INSERT);
    hold_reqs++;
    repeat (6) push_point(pick_point());
    settle();
    last_ic = lin_ups_pkg::MAX_POINTS;

    while (points_queued < 270) begin
      idle_on = (points_queued < 230) && ($urandom_range(0, 3) != 0);
      r = $urandom_range(0, 9);
      if (r == 0) begin
        case ($urandom_range(0, 3))
          0: begin
            ic = $urandom_range(2, 20);
            oc = $urandom_range(0, ic);
          end
          1: begin
            ic = $urandom_range(0, 1);
            oc = $urandom_range(0, 262143);
          end
          2: begin
            ic = $urandom_range(lin_ups_pkg::MAX_POINTS + 1, 8191);
            oc = $urandom_range(0, 262143);
          end
          default: begin
            ic = $urandom_range(2, 20);
            oc = ic + (ic - 1) * lin_ups_pkg::MAX_INSERT + $urandom_range(1, 500);
          end
        endcase
        nv = $urandom_range(1, 4);
      end else begin
        ic   = $urandom_range(2, (r < 3) ? 30 : 8);
        segs = ic - 1;
        if (r == 1) oc = ic + segs * lin_ups_pkg::MAX_INSERT;
        else oc = ic + $urandom_range(1, segs * (($urandom_range(0, 1) != 0) ?
                                                 lin_ups_pkg::MAX_INSERT : 3));
        nv = ic * $urandom_range(1, 2);
        // broken vector: stop partway, the next write restarts it
        if ($urandom_range(0, 4) == 0) nv += $urandom_range(1, ic - 1);
      end
      if (ic != last_ic || $urandom_range(0, 1) != 0)
        write_reg(lin_ups_pkg::CFG_INPUT_COUNT, ic);
      write_reg(lin_ups_pkg::CFG_OUTPUT_COUNT, oc);
      last_ic = ic;
      repeat (nv) push_point(pick_point());
      settle();
    end

    if (fails == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  initial begin
    #10ms;
    $display("Some tests failed");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/lin_ups_pkg.sv
rtl/core/lin_ups_div.sv
rtl/core/lin_ups_front.sv
rtl/core/lin_ups_queue.sv
rtl/core/lin_ups_back.sv
rtl/core/linear_interpolating_upsampler.sv
rtl/core/lin_ups_checker.sv
sim/linear_interpolating_upsampler_tb.sv
